@@ hdl/bse_pkg.sv @@
// shared types and constants of the burning ship escape-time engine
package bse_pkg;

  localparam int unsigned IMG_WIDTH  = 1024;
  localparam int unsigned IMG_HEIGHT = 1024;

  localparam int unsigned PIX_W      = 10;
  localparam int unsigned OFF_W      = 21;
  localparam int unsigned STEP_W     = 32;
  localparam int unsigned C_W        = 32;
  localparam int unsigned CNT_W      = 12;
  localparam int unsigned Q_W        = 36;
  localparam int unsigned FRAC_W     = 28;
  localparam int unsigned HALF_W     = Q_W / 2;
  // pixel distance from the centre plus pan, raster sizes up to 4096
  localparam int unsigned MAP_W      = 22;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic signed [MAP_W-1:0] HALF_WIDTH  = MAP_W'(IMG_WIDTH / 2);
  localparam logic signed [MAP_W-1:0] HALF_HEIGHT = MAP_W'(IMG_HEIGHT / 2);

  localparam logic [STEP_W-1:0] STEP_RESET     = STEP_W'(32'd16777216);
  localparam logic [CNT_W-1:0]  MAX_ITER_RESET = CNT_W'(12'd50);

  // escape radius squared, 4 in q8.28
  localparam logic [Q_W:0] ESCAPE_LIMIT = (Q_W + 1)'(4) << FRAC_W;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MAP_MUL,
    OP_MAP_ADD,
    OP_UPDATE,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_COMBINE
  } op_e;

endpackage

@@ hdl/bse_mul.sv @@
// two-pass 36x18 multiplier with floor shift and saturation to 2^35 - 1
module bse_mul #(
  parameter int unsigned SHIFT = 28
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bse_pkg::op_e           op_i,
  input  logic [bse_pkg::Q_W-1:0] a_i,
  input  logic [bse_pkg::Q_W-1:0] b_i,
  output logic [bse_pkg::Q_W-1:0] res_o
);

  localparam int unsigned PP_W   = bse_pkg::Q_W + bse_pkg::HALF_W;
  localparam int unsigned FULL_W = 2 * bse_pkg::Q_W;

  logic [PP_W-1:0]         pl_q;
  logic [PP_W-1:0]         ph_q;
  logic [bse_pkg::Q_W-1:0] res_q;
  logic [bse_pkg::Q_W-1:0] res_d;
  logic [FULL_W-1:0]       full;
  logic                    over;

  assign full = {ph_q, {bse_pkg::HALF_W{1'b0}}} + FULL_W'(pl_q);
  // anything at or above 2^(shift+35) clips
  assign over = |full[FULL_W-1:SHIFT+bse_pkg::Q_W-1];

  always_comb begin
    if (over) begin
      res_d = {1'b0, {(bse_pkg::Q_W-1){1'b1}}};
    end else begin
      res_d = {1'b0, full[SHIFT+bse_pkg::Q_W-2:SHIFT]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pl_q  <= '0;
      ph_q  <= '0;
      res_q <= '0;
    end else begin
      case (op_i)
        bse_pkg::OP_MUL_LO:  pl_q  <= PP_W'(a_i) * PP_W'(b_i[bse_pkg::HALF_W-1:0]);
        bse_pkg::OP_MUL_HI:  ph_q  <= PP_W'(a_i) * PP_W'(b_i[bse_pkg::Q_W-1:bse_pkg::HALF_W]);
        bse_pkg::OP_COMBINE: res_q <= res_d;
        bse_pkg::OP_MAP_ADD: res_q <= '0;
        default: ;
      endcase
    end
  end

  assign res_o = res_q;

endmodule

@@ hdl/bse_dp.sv @@
// datapath: pixel to plane mapping and the burning ship recurrence
module bse_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bse_pkg::op_e                     op_i,
  input  logic [bse_pkg::PIX_W-1:0]        pixel_x_i,
  input  logic [bse_pkg::PIX_W-1:0]        pixel_y_i,
  input  logic signed [bse_pkg::OFF_W-1:0] offset_x_i,
  input  logic signed [bse_pkg::OFF_W-1:0] offset_y_i,
  input  logic [bse_pkg::STEP_W-1:0]       step_size_i,
  input  logic signed [bse_pkg::C_W-1:0]   adjust_x_i,
  input  logic signed [bse_pkg::C_W-1:0]   adjust_y_i,
  output logic                             escaped_o
);

  localparam int unsigned PROD_W    = bse_pkg::MAP_W + bse_pkg::STEP_W + 1;
  localparam int unsigned MAP_SHIFT = 4;
  localparam int unsigned SUM_W     = PROD_W - MAP_SHIFT + 1;
  localparam int unsigned IT_W      = bse_pkg::Q_W + 2;

  localparam logic [bse_pkg::Q_W-1:0] Q_MAX = {1'b0, {(bse_pkg::Q_W-1){1'b1}}};
  localparam logic [bse_pkg::Q_W-1:0] Q_MIN = {1'b1, {(bse_pkg::Q_W-1){1'b0}}};
  localparam logic [bse_pkg::C_W-1:0] C_MAX = {1'b0, {(bse_pkg::C_W-1){1'b1}}};
  localparam logic [bse_pkg::C_W-1:0] C_MIN = {1'b1, {(bse_pkg::C_W-1){1'b0}}};

  logic signed [bse_pkg::MAP_W-1:0] px_s, py_s, ox_s, oy_s;
  logic signed [bse_pkg::MAP_W-1:0] map_x_q, map_y_q;
  logic signed [PROD_W-1:0]         prod_x_q, prod_y_q;
  logic signed [SUM_W-1:0]          cx_sum, cy_sum;
  logic [bse_pkg::C_W-1:0]          cx_d, cy_d;
  logic signed [bse_pkg::C_W-1:0]   cx_q, cy_q;
  logic [bse_pkg::Q_W-1:0]          x_q, y_q, x_d, y_d;
  logic [bse_pkg::Q_W-1:0]          mag_x, mag_y;
  logic [bse_pkg::Q_W-1:0]          x2, y2, txy;
  logic signed [IT_W-1:0]           nx_sum, ny_sum;
  logic [bse_pkg::Q_W:0]            rad_sum;

  // coordinate set-up
  assign px_s = bse_pkg::MAP_W'(pixel_x_i);
  assign py_s = bse_pkg::MAP_W'(pixel_y_i);
  assign ox_s = bse_pkg::MAP_W'(offset_x_i);
  assign oy_s = bse_pkg::MAP_W'(offset_y_i);

  assign cx_sum = SUM_W'($signed(prod_x_q[PROD_W-1:MAP_SHIFT])) + SUM_W'(adjust_x_i);
  assign cy_sum = SUM_W'($signed(prod_y_q[PROD_W-1:MAP_SHIFT])) + SUM_W'(adjust_y_i);

  always_comb begin
    if (&cx_sum[SUM_W-1:bse_pkg::C_W-1] || ~|cx_sum[SUM_W-1:bse_pkg::C_W-1]) begin
      cx_d = cx_sum[bse_pkg::C_W-1:0];
    end else begin
      cx_d = cx_sum[SUM_W-1] ? C_MIN : C_MAX;
    end
    if (&cy_sum[SUM_W-1:bse_pkg::C_W-1] || ~|cy_sum[SUM_W-1:bse_pkg::C_W-1]) begin
      cy_d = cy_sum[bse_pkg::C_W-1:0];
    end else begin
      cy_d = cy_sum[SUM_W-1] ? C_MIN : C_MAX;
    end
  end

  // one round of the recurrence
  assign nx_sum = $signed({2'b00, x2}) - $signed({2'b00, y2}) + IT_W'(cx_q);
  assign ny_sum = $signed({2'b00, txy}) + IT_W'(cy_q);

  always_comb begin
    if (&nx_sum[IT_W-1:bse_pkg::Q_W-1] || ~|nx_sum[IT_W-1:bse_pkg::Q_W-1]) begin
      x_d = nx_sum[bse_pkg::Q_W-1:0];
    end else begin
      x_d = nx_sum[IT_W-1] ? Q_MIN : Q_MAX;
    end
    if (&ny_sum[IT_W-1:bse_pkg::Q_W-1] || ~|ny_sum[IT_W-1:bse_pkg::Q_W-1]) begin
      y_d = ny_sum[bse_pkg::Q_W-1:0];
    end else begin
      y_d = ny_sum[IT_W-1] ? Q_MIN : Q_MAX;
    end
  end

  assign mag_x = x_q[bse_pkg::Q_W-1] ? (~x_q + bse_pkg::Q_W'(1)) : x_q;
  assign mag_y = y_q[bse_pkg::Q_W-1] ? (~y_q + bse_pkg::Q_W'(1)) : y_q;

  assign rad_sum   = {1'b0, x2} + {1'b0, y2};
  assign escaped_o = rad_sum > bse_pkg::ESCAPE_LIMIT;

  always_ff @(posedge clk_i) begin
    case (op_i)
      bse_pkg::OP_LOAD: begin
        map_x_q <= px_s - bse_pkg::HALF_WIDTH + ox_s;
        map_y_q <= py_s - bse_pkg::HALF_HEIGHT - oy_s;
      end
      bse_pkg::OP_MAP_MUL: begin
        prod_x_q <= PROD_W'(map_x_q) * PROD_W'($signed({1'b0, step_size_i}));
        prod_y_q <= PROD_W'(map_y_q) * PROD_W'($signed({1'b0, step_size_i}));
      end
      bse_pkg::OP_MAP_ADD: begin
        cx_q <= cx_d;
        cy_q <= cy_d;
        x_q  <= '0;
        y_q  <= '0;
      end
      bse_pkg::OP_UPDATE: begin
        x_q <= x_d;
        y_q <= y_d;
      end
      default: ;
    endcase
  end

  bse_mul #(.SHIFT(bse_pkg::FRAC_W)) u_mul_xx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op_i),
    .a_i    (mag_x),
    .b_i    (mag_x),
    .res_o  (x2)
  );

  bse_mul #(.SHIFT(bse_pkg::FRAC_W)) u_mul_yy (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op_i),
    .a_i    (mag_y),
    .b_i    (mag_y),
    .res_o  (y2)
  );

  // doubling folded into the shift
  bse_mul #(.SHIFT(bse_pkg::FRAC_W - 1)) u_mul_xy (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op_i),
    .a_i    (mag_x),
    .b_i    (mag_y),
    .res_o  (txy)
  );

endmodule

@@ hdl/bse_ctrl.sv @@
// controller: sequences mapping and iteration rounds, holds count and result register
module bse_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [bse_pkg::CNT_W-1:0] max_iter_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      escaped_i,
  output bse_pkg::op_e              op_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [bse_pkg::CNT_W-1:0] iter_count_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_MUL,
    ST_MAP_ADD,
    ST_UPDATE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_COMBINE,
    ST_FINISH
  } state_e;

  state_e                    state_q, state_d;
  logic [bse_pkg::CNT_W-1:0] count_q, count_d;
  logic [bse_pkg::CNT_W-1:0] iter_count_q, iter_count_d;
  logic                      out_valid_q, out_valid_d;
  logic                      go_on;

  assign go_on = !escaped_i && (count_q < max_iter_i);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    iter_count_d = iter_count_q;
    out_valid_d  = out_valid_q;
    op_o         = bse_pkg::OP_NONE;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_o    = bse_pkg::OP_LOAD;
          state_d = ST_MAP_MUL;
        end
      end
      ST_MAP_MUL: begin
        op_o    = bse_pkg::OP_MAP_MUL;
        state_d = ST_MAP_ADD;
      end
      ST_MAP_ADD: begin
        op_o    = bse_pkg::OP_MAP_ADD;
        count_d = '0;
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (go_on) begin
          op_o    = bse_pkg::OP_UPDATE;
          count_d = count_q + bse_pkg::CNT_W'(1);
          state_d = ST_MUL_LO;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_MUL_LO: begin
        op_o    = bse_pkg::OP_MUL_LO;
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        op_o    = bse_pkg::OP_MUL_HI;
        state_d = ST_COMBINE;
      end
      ST_COMBINE: begin
        op_o    = bse_pkg::OP_COMBINE;
        state_d = ST_UPDATE;
      end
      ST_FINISH: begin
        // wait for the result register to drain
        if (!out_valid_q || out_ready_i) begin
          iter_count_d = count_q;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      iter_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      iter_count_q <= iter_count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign iter_count_o = iter_count_q;

endmodule

@@ hdl/burning_ship_escape_time.sv @@
// burning ship escape-time engine: config registers, controller and datapath
//
// usage:
//   write the view registers (offset_x, offset_y, step_size, adjust_x, adjust_y,
//   max_iter) through cfg_we_i / cfg_index_i / cfg_data_i while nothing is in flight;
//   unknown indexes are ignored.
//   present a pixel request on pixel_x_i / pixel_y_i with in_valid_i; it is taken
//   when in_ready_o is high. the pixel is centred, panned, scaled by the step and
//   shifted by the adjust to give c, then each iteration round steps through update,
//   low partial products, high partial products and combine, all on three shared
//   36x18 multipliers. one pixel is in flight at a time, so a new request is taken
//   only after the previous one has finished, with the multiplier rounds setting
//   the pace.
//   the result sits in an output register until out_ready_i takes it; a new request
//   is accepted meanwhile, and the engine only waits at the end of that request if
//   the previous result has still not been taken.
//   reset empties the engine and the output register and restores the register
//   defaults: step 2^-8, max_iter 50, everything else zero.
module burning_ship_escape_time (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bse_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bse_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bse_pkg::PIX_W-1:0]      pixel_x_i,
  input  logic [bse_pkg::PIX_W-1:0]      pixel_y_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bse_pkg::CNT_W-1:0]      iter_count_o
);

  localparam logic [bse_pkg::CFG_IDX_W-1:0] REG_OFFSET_X = 3'd0;
  localparam logic [bse_pkg::CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd1;
  localparam logic [bse_pkg::CFG_IDX_W-1:0] REG_STEP     = 3'd2;
  localparam logic [bse_pkg::CFG_IDX_W-1:0] REG_ADJUST_X = 3'd3;
  localparam logic [bse_pkg::CFG_IDX_W-1:0] REG_ADJUST_Y = 3'd4;
  localparam logic [bse_pkg::CFG_IDX_W-1:0] REG_MAX_ITER = 3'd5;

  logic signed [bse_pkg::OFF_W-1:0] offset_x_q, offset_y_q;
  logic [bse_pkg::STEP_W-1:0]       step_size_q;
  logic signed [bse_pkg::C_W-1:0]   adjust_x_q, adjust_y_q;
  logic [bse_pkg::CNT_W-1:0]        max_iter_q;
  bse_pkg::op_e                     dp_op;
  logic                             dp_escaped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q  <= '0;
      offset_y_q  <= '0;
      step_size_q <= bse_pkg::STEP_RESET;
      adjust_x_q  <= '0;
      adjust_y_q  <= '0;
      max_iter_q  <= bse_pkg::MAX_ITER_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_OFFSET_X: offset_x_q  <= cfg_data_i[bse_pkg::OFF_W-1:0];
        REG_OFFSET_Y: offset_y_q  <= cfg_data_i[bse_pkg::OFF_W-1:0];
        REG_STEP:     step_size_q <= cfg_data_i[bse_pkg::STEP_W-1:0];
        REG_ADJUST_X: adjust_x_q  <= cfg_data_i[bse_pkg::C_W-1:0];
        REG_ADJUST_Y: adjust_y_q  <= cfg_data_i[bse_pkg::C_W-1:0];
        REG_MAX_ITER: max_iter_q  <= cfg_data_i[bse_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  bse_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_iter_i   (max_iter_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .escaped_i    (dp_escaped),
    .op_o         (dp_op),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .iter_count_o (iter_count_o)
  );

  bse_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (dp_op),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .offset_x_i  (offset_x_q),
    .offset_y_i  (offset_y_q),
    .step_size_i (step_size_q),
    .adjust_x_i  (adjust_x_q),
    .adjust_y_i  (adjust_y_q),
    .escaped_o   (dp_escaped)
  );

  // only a load or nothing may reach the datapath while waiting for a request
  a_idle_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (dp_op == bse_pkg::OP_NONE || dp_op == bse_pkg::OP_LOAD))
    else $error("datapath busy while controller idle");

  a_accept_maps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (dp_op == bse_pkg::OP_MAP_MUL))
    else $error("accepted request not followed by mapping");

  a_mul_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_op == bse_pkg::OP_MUL_LO) |=>
      (dp_op == bse_pkg::OP_MUL_HI) ##1 (dp_op == bse_pkg::OP_COMBINE))
    else $error("partial product sequence broken");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result issued while engine still busy");

endmodule
